// ===== src/cdte_pkg.sv =====
// -----------------------------------------------------------------------------
// cdte_pkg: civil date-time to epoch milliseconds, shared types and tables
// item and result layouts, calendar tables and constant-divide helpers
// -----------------------------------------------------------------------------
package cdte_pkg;

	typedef struct packed {
		logic signed [15:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic [29:0]        nanos;
	} dt_item_t;

	typedef struct packed {
		logic signed [50:0] stamp_ms;
		logic               status;
	} dt_result_t;

	localparam int unsigned DAYS_PER_ERA = 146097;
	localparam int unsigned EPOCH_SHIFT  = 719468;
	// whole eras added so that every year of the range becomes non-negative
	localparam int unsigned ERA_OFFSET   = 82;
	localparam int unsigned YEAR_BIAS    = ERA_OFFSET * 400;
	localparam int unsigned EPOCH_BIAS   = ERA_OFFSET * DAYS_PER_ERA + EPOCH_SHIFT;

	localparam logic [29:0] NANOS_MAX     = 30'd999999999;
	localparam logic [26:0] MS_PER_HOUR   = 27'd3600000;
	localparam logic [26:0] MS_PER_MINUTE = 27'd60000;
	localparam logic [26:0] MS_PER_SECOND = 27'd1000;
	localparam logic signed [27:0] MS_PER_DAY = 28'sd86400000;

	// nanos / 1e6 == (nanos >> 6) / 15625, done as multiply by reciprocal
	localparam logic [24:0] NS_RECIP = 25'd17592187;
	localparam int unsigned NS_SHIFT = 38;

	localparam logic [12:0] DIV25_RECIP = 13'd5243;
	localparam int unsigned DIV25_SHIFT = 17;

	// exact floor(x / 25) for any 15-bit x
	function automatic logic [10:0] div25(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * 28'(DIV25_RECIP);
		return p[27:DIV25_SHIFT];
	endfunction

	// days before the first of the month, in a year that starts in march
	function automatic logic [8:0] month_offset(input logic [3:0] m);
		logic [8:0] r;
		unique case (m)
			4'd1:    r = 9'd306;
			4'd2:    r = 9'd337;
			4'd3:    r = 9'd0;
			4'd4:    r = 9'd31;
			4'd5:    r = 9'd61;
			4'd6:    r = 9'd92;
			4'd7:    r = 9'd122;
			4'd8:    r = 9'd153;
			4'd9:    r = 9'd184;
			4'd10:   r = 9'd214;
			4'd11:   r = 9'd245;
			4'd12:   r = 9'd275;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// month length, zero for a month number that means nothing
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
			4'd2:                                       r = leap ? 5'd29 : 5'd28;
			default:                                    r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/civil_datetime_to_epoch_millis.sv =====
// -----------------------------------------------------------------------------
// civil_datetime_to_epoch_millis: proleptic gregorian date-time to epoch ms
// checks the fields of each item and converts valid ones with days-from-civil
// -----------------------------------------------------------------------------
//
//  channel   strobe / ready     payload              direction
//  -------   ---------------    -------------------  ---------
//  request   start / busy       item   (dt_item_t)   in
//  result    done               result (dt_result_t) out
//
//  one item per cycle: five register stages, no loop and no shared unit
//  busy is always low, the pipeline never holds an item back
//  results cannot be stalled, so every stage simply advances each cycle
//  arst_n clears the stage valid bits only; payload registers are not reset
//
module civil_datetime_to_epoch_millis (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cdte_pkg::dt_item_t    item,
	output logic                  done,
	output cdte_pkg::dt_result_t  result
);

	// stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// -------------------------------------------------------------------------
	// stage 1: range checks, year bias, day of the march-based year
	// -------------------------------------------------------------------------
	logic        accept;
	logic [16:0] yr_d;           // year + 32800, same residue mod 400
	logic [16:0] yp_d;           // biased year, january and february count back
	logic        range_ok_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign yr_d = {item.year[15], item.year} + 17'(cdte_pkg::YEAR_BIAS);
	assign yp_d = yr_d - 17'((item.month <= 4'd2) ? 1 : 0);

	assign range_ok_d = (item.month >= 4'd1) && (item.month <= 4'd12) &&
		(item.day != 5'd0) && (item.hour <= 5'd23) &&
		(item.minute <= 6'd59) && (item.second <= 6'd59) &&
		(item.nanos <= cdte_pkg::NANOS_MAX);

	logic [16:0] yr_s1, yp_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [8:0]  doy_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1, second_s1;
	logic [23:0] nanos_hi_s1;
	logic        ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		yr_s1       <= yr_d;
		yp_s1       <= yp_d;
		month_s1    <= item.month;
		day_s1      <= item.day;
		// a zero day wraps here, but the item is then flagged invalid
		doy_s1      <= cdte_pkg::month_offset(item.month) + 9'(item.day) - 9'd1;
		hour_s1     <= item.hour;
		minute_s1   <= item.minute;
		second_s1   <= item.second;
		nanos_hi_s1 <= item.nanos[29:6];
		ok_s1       <= range_ok_d;
	end

	// -------------------------------------------------------------------------
	// stage 2: multiplies by constants, each result registered
	// -------------------------------------------------------------------------
	logic [48:0] nanos_prod_d;

	assign nanos_prod_d = 49'(nanos_hi_s1) * 49'(cdte_pkg::NS_RECIP);

	logic [16:0] yr_s2, yp_s2;
	logic [3:0]  month_s2;
	logic [4:0]  day_s2;
	logic [8:0]  doy_s2;
	logic [24:0] y365_s2;
	logic [10:0] yp_q100_s2, yp_q400_s2;   // floor(yp/100), floor(yp/400)
	logic [10:0] yr_q100_s2, yr_q400_s2;   // for the leap-year test
	logic [26:0] hour_ms_s2, minute_ms_s2, second_ms_s2;
	logic [9:0]  nanos_ms_s2;
	logic        ok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		yr_s2        <= yr_s1;
		yp_s2        <= yp_s1;
		month_s2     <= month_s1;
		day_s2       <= day_s1;
		doy_s2       <= doy_s1;
		y365_s2      <= 25'(yp_s1) * 25'd365;
		yp_q100_s2   <= cdte_pkg::div25(yp_s1[16:2]);
		yp_q400_s2   <= cdte_pkg::div25(15'(yp_s1[16:4]));
		yr_q100_s2   <= cdte_pkg::div25(yr_s1[16:2]);
		yr_q400_s2   <= cdte_pkg::div25(15'(yr_s1[16:4]));
		hour_ms_s2   <= 27'(hour_s1) * cdte_pkg::MS_PER_HOUR;
		minute_ms_s2 <= 27'(minute_s1) * cdte_pkg::MS_PER_MINUTE;
		second_ms_s2 <= 27'(second_s1) * cdte_pkg::MS_PER_SECOND;
		// truncated nanos-to-millis, exact for every nanos up to the valid limit
		nanos_ms_s2  <= nanos_prod_d[cdte_pkg::NS_SHIFT+9:cdte_pkg::NS_SHIFT];
		ok_s2        <= ok_s1;
	end

	// -------------------------------------------------------------------------
	// stage 3: leap year and day check, day count, time of day
	// -------------------------------------------------------------------------
	logic        div4_d, div100_d, div400_d, leap_d;
	logic [4:0]  mlen_d;
	logic [25:0] days_w;
	logic [26:0] tod_d;

	// yr/100 exact when yr is a multiple of 4 and (yr>>2) is a multiple of 25
	assign div4_d   = (yr_s2[1:0] == 2'd0);
	assign div100_d = div4_d && (16'(yr_s2[16:2]) == 16'(yr_q100_s2) * 16'd25);
	assign div400_d = (yr_s2[3:0] == 4'd0) &&
		(16'(yr_s2[16:4]) == 16'(yr_q400_s2) * 16'd25);
	assign leap_d   = div4_d && (!div100_d || div400_d);
	assign mlen_d   = cdte_pkg::month_days(month_s2, leap_d);

	// days since the epoch for a non-negative year: eras cancel exactly
	assign days_w = 26'(y365_s2) + 26'(yp_s2[16:2]) - 26'(yp_q100_s2) +
		26'(yp_q400_s2) + 26'(doy_s2) - 26'(cdte_pkg::EPOCH_BIAS);

	assign tod_d = hour_ms_s2 + minute_ms_s2 + second_ms_s2 + 27'(nanos_ms_s2);

	logic signed [24:0] days_s3;
	logic [26:0]        tod_s3;
	logic               ok_s3;
	logic [3:0]         month_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		days_s3  <= signed'(days_w[24:0]);
		tod_s3   <= tod_d;
		ok_s3    <= ok_s2 && (day_s2 <= mlen_d);
		month_s3 <= month_s2;
	end

	// -------------------------------------------------------------------------
	// stage 4: days to milliseconds
	// -------------------------------------------------------------------------
	logic signed [51:0] day_ms_s4;
	logic [26:0]        tod_s4;
	logic               ok_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		day_ms_s4 <= 52'(days_s3) * 52'(cdte_pkg::MS_PER_DAY);
		tod_s4    <= tod_s3;
		ok_s4     <= ok_s3;
	end

	// -------------------------------------------------------------------------
	// stage 5: final sum, invalid items give zero and status set
	// -------------------------------------------------------------------------
	logic [51:0]          millis_d;
	cdte_pkg::dt_result_t result_s5;

	assign millis_d = unsigned'(day_ms_s4) + 52'(tod_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		result_s5.stamp_ms <= ok_s4 ? signed'(millis_d[50:0]) : 51'sd0;
		result_s5.status   <= !ok_s4;
	end

	assign done   = vld_s5;
	assign result = result_s5;

	// -------------------------------------------------------------------------
	// assertions
	// -------------------------------------------------------------------------
	// every accepted item gives exactly one result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 == $past(accept, 5))
		else $error("result strobe does not match accepted items");

	// an invalid item carries a zero timestamp
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status |-> result.stamp_ms == 51'sd0)
		else $error("invalid item with nonzero timestamp");

	// a valid conversion never comes from a month number outside the year
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && ok_s3 |-> (month_s3 >= 4'd1) && (month_s3 <= 4'd12))
		else $error("valid flag set for a bad month");

	// the day count of a valid item stays inside the supported year range
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && ok_s4 |-> (day_ms_s4 < 52'sd1100000000000000) &&
			(day_ms_s4 > -52'sd1100000000000000))
		else $error("day count out of range");

endmodule

// ===== tb/tb_civil_datetime_to_epoch_millis.sv =====
// -----------------------------------------------------------------------------
// tb_civil_datetime_to_epoch_millis: self-checking bench for the epoch converter
// drives directed calendar corners and random date-time items through the block,
// predicts every result in the bench and compares it field by field
// -----------------------------------------------------------------------------
module tb_civil_datetime_to_epoch_millis;
	timeunit 1ns;
	timeprecision 1ps;

	// pipeline depth given at the head of the block
	localparam int LATENCY     = 5;
	// watchdog budget, far above what a legal run takes
	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_PER_PHASE = 240;

	// -------------------------------------------------------------------------
	// expected-result ledger: predicts each accepted item and checks results
	// -------------------------------------------------------------------------
	class epoch_ledger;
		localparam longint ERA_DAYS    = 146097;
		localparam longint SHIFT_DAYS  = 719468;
		localparam longint DAY_MS      = 86400000;
		localparam longint HOUR_MS     = 3600000;
		localparam longint MINUTE_MS   = 60000;
		localparam longint SECOND_MS   = 1000;
		localparam longint MS_NS       = 1000000;
		localparam longint NS_LIMIT    = 999999999;
		localparam int     FEB         = 2;
		localparam logic   ST_OK       = 1'b0;
		localparam logic   ST_BAD      = 1'b1;

		cdte_pkg::dt_result_t expected_q[$];
		int unsigned          errors;

		function new();
			errors = 0;
		endfunction

		// gregorian 4/100/400 rule, also for year zero and negative years
		static function bit is_leap(longint y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		// length of a month in 1..12
		static function int month_len(int m, bit leap);
			case (m)
				FEB: begin
					return leap ? 29 : 28;
				end
				4, 6, 9, 11: begin
					return 30;
				end
				default: begin
					return 31;
				end
			endcase
		endfunction

		// era-based day count from the civil date, then add time of day in ms
		static function cdte_pkg::dt_result_t predict(cdte_pkg::dt_item_t it);
			cdte_pkg::dt_result_t r;
			longint     y, m, d, hh, mi, ss, ns;
			longint     yy, era, yoe, mp, doy, doe, days, ms;
			bit         ok;
			y  = longint'($signed(it.year));
			m  = longint'(it.month);
			d  = longint'(it.day);
			hh = longint'(it.hour);
			mi = longint'(it.minute);
			ss = longint'(it.second);
			ns = longint'(it.nanos);
			ok = (m >= 1) && (m <= 12);
			if (ok)
				ok = (d >= 1) && (d <= month_len(int'(m), is_leap(y)));
			ok = ok && (hh <= 23) && (mi <= 59) && (ss <= 59) && (ns <= NS_LIMIT);
			r = '0;
			if (!ok) begin
				r.status = ST_BAD;
			end else begin
				// the year starts in march so that february falls at its end
				yy   = (m <= FEB) ? y - 1 : y;
				era  = (yy >= 0 ? yy : yy - 399) / 400;
				yoe  = yy - era * 400;
				mp   = (m > FEB) ? m - 3 : m + 9;
				doy  = (153 * mp + 2) / 5 + d - 1;
				doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
				days = era * ERA_DAYS + doe - SHIFT_DAYS;
				ms   = days * DAY_MS + hh * HOUR_MS + mi * MINUTE_MS + ss * SECOND_MS
				       + ns / MS_NS;
				r.stamp_ms = ms[50:0];
				r.status   = ST_OK;
			end
			return r;
		endfunction

		function void note_item(cdte_pkg::dt_item_t it);
			expected_q = {expected_q, predict(it)};
		endfunction

		function void check_result(cdte_pkg::dt_result_t got);
			cdte_pkg::dt_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: stamp_ms %0d status %0b",
					$time, got.stamp_ms, got.status);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0b actual %0b",
					$time, want.status, got.status);
			end
			if (got.stamp_ms !== want.stamp_ms) begin
				errors++;
				$display("%0t: stamp_ms mismatch: expected %0d actual %0d",
					$time, want.stamp_ms, got.stamp_ms);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// -------------------------------------------------------------------------
	// block hookup
	// -------------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 done;
	cdte_pkg::dt_item_t   item;
	cdte_pkg::dt_result_t result;

	int unsigned cycles = 0;
	epoch_ledger ledger = new();

	civil_datetime_to_epoch_millis u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// watchdog: a hung pipeline or a lost result ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// sample at the rising edge: an item is taken when start is high and busy
	// low, a result is taken whenever done is high (no back-pressure exists)
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				ledger.note_item(item);
			if (done)
				ledger.check_result(result);
		end
	end

	// -------------------------------------------------------------------------
	// stimulus helpers
	// -------------------------------------------------------------------------
	function automatic cdte_pkg::dt_item_t make_item(int y, int mo, int d, int h, int mi,
		int s, int ns);
		cdte_pkg::dt_item_t it;
		it.year   = 16'(y);
		it.month  = 4'(mo);
		it.day    = 5'(d);
		it.hour   = 5'(h);
		it.minute = 6'(mi);
		it.second = 6'(s);
		it.nanos  = 30'(ns);
		return it;
	endfunction

	// mostly well-formed date-times, some with one field pushed out of range,
	// the rest raw bits so every input bit sees both values
	function automatic cdte_pkg::dt_item_t random_item();
		cdte_pkg::dt_item_t it;
		logic [95:0] raw;
		int          kind, pick, yv, len;
		raw  = {$urandom, $urandom, $urandom};
		kind = $urandom_range(99);
		if (kind >= 85)
			return raw[71:0];
		pick = $urandom_range(9);
		if (pick < 5)
			yv = int'($signed(raw[15:0]));
		else if (pick < 8)
			yv = 1900 + int'($urandom_range(200));
		else if (pick == 8)
			yv = -32768 + int'($urandom_range(3));
		else
			yv = 32767 - int'($urandom_range(3));
		it.year   = 16'(yv);
		it.month  = 4'($urandom_range(1, 12));
		len       = epoch_ledger::month_len(int'(it.month), epoch_ledger::is_leap(yv));
		// last day of the month gets extra weight
		it.day    = ($urandom_range(3) == 0) ? 5'(len) : 5'($urandom_range(1, len));
		it.hour   = 5'($urandom_range(23));
		it.minute = 6'($urandom_range(59));
		it.second = 6'($urandom_range(59));
		it.nanos  = 30'($urandom_range(999999999));
		if (kind >= 70) begin
			case ($urandom_range(5))
				0: it.month  = $urandom_range(1) ? 4'd0 : 4'($urandom_range(13, 15));
				1: it.day    = (len == 31 || $urandom_range(1)) ? 5'd0
				               : 5'($urandom_range(len + 1, 31));
				2: it.hour   = 5'($urandom_range(24, 31));
				3: it.minute = 6'($urandom_range(60, 63));
				4: it.second = 6'($urandom_range(60, 63));
				default: it.nanos = 30'($urandom_range(1000000000, 30'h3FFFFFFF));
			endcase
		end
		return it;
	endfunction

	// called at a falling edge; idles with start low first, garbage on the bus,
	// then holds the item until the block takes it and returns at a falling edge
	task automatic send_item(input cdte_pkg::dt_item_t it, input int unsigned idle_pct);
		logic [95:0] junk;
		while ($urandom_range(99) < idle_pct) begin
			junk  = {$urandom, $urandom, $urandom};
			start <= 1'b0;
			item  <= junk[71:0];
			@(negedge clk);
		end
		item  <= it;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// -------------------------------------------------------------------------
	// test sequence
	// -------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned phase_idle [4];
		// no idling, sender mostly idle, receiver stall (not possible here, so
		// back to back again), light idling on the sender
		phase_idle[0] = 0;
		phase_idle[1] = 74;
		phase_idle[2] = 0;
		phase_idle[3] = 11;

		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// epoch itself and the millisecond just before it
		send_item(make_item(1970, 1, 1, 0, 0, 0, 0), 0);
		send_item(make_item(1969, 12, 31, 23, 59, 59, 999999999), 0);
		// both ends of the year range
		send_item(make_item(-32768, 1, 1, 0, 0, 0, 0), 0);
		send_item(make_item(32767, 12, 31, 23, 59, 59, 999999999), 0);
		send_item(make_item(-32768, 2, 29, 1, 2, 3, 4000000), 0);
		// leap rules: by 400, not by 100, by 4, year zero and negative years
		send_item(make_item(2000, 2, 29, 12, 30, 45, 123456789), 0);
		send_item(make_item(1900, 2, 29, 0, 0, 0, 0), 0);
		send_item(make_item(1900, 2, 28, 23, 59, 59, 999999), 0);
		send_item(make_item(2023, 2, 29, 0, 0, 0, 0), 0);
		send_item(make_item(0, 2, 29, 6, 7, 8, 9), 0);
		send_item(make_item(-100, 2, 29, 0, 0, 0, 0), 0);
		send_item(make_item(-400, 2, 29, 0, 0, 0, 0), 0);
		send_item(make_item(-1, 3, 1, 0, 0, 0, 0), 0);
		// month and day out of range, and the last day of january
		send_item(make_item(2024, 0, 1, 0, 0, 0, 0), 0);
		send_item(make_item(2024, 13, 1, 0, 0, 0, 0), 0);
		send_item(make_item(2024, 15, 31, 0, 0, 0, 0), 0);
		send_item(make_item(2024, 4, 31, 0, 0, 0, 0), 0);
		send_item(make_item(2024, 1, 0, 0, 0, 0, 0), 0);
		send_item(make_item(2024, 1, 31, 23, 0, 0, 0), 0);
		// time-of-day fields just past their limits and at all ones
		send_item(make_item(2024, 6, 15, 24, 0, 0, 0), 0);
		send_item(make_item(2024, 6, 15, 31, 0, 0, 0), 0);
		send_item(make_item(2024, 6, 15, 0, 60, 0, 0), 0);
		send_item(make_item(2024, 6, 15, 0, 63, 63, 0), 0);
		send_item(make_item(2024, 6, 15, 0, 0, 60, 0), 0);
		send_item(make_item(2024, 6, 15, 0, 0, 0, 1000000000), 0);
		send_item(make_item(2024, 6, 15, 0, 0, 0, 32'h3FFFFFFF), 0);

		for (int p = 0; p < 4; p++)
			repeat (RANDOM_PER_PHASE) send_item(random_item(), phase_idle[p]);
		start <= 1'b0;

		// drain, then keep watching for any stray result to show up
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
